FILE: hw/rtl/vcl_pkg.sv
`timescale 1ns / 1ps
package vcl_pkg;

    localparam int LIM_W    = 15;
    localparam int TMO_W    = 16;
    localparam int INV_W    = 3;
    localparam int CFG_W    = 16;
    localparam int IDX_W    = 3;

    localparam int PROD_W   = 2 * LIM_W;
    localparam int ACC_W    = 2 * PROD_W + 1;
    localparam int SQ_W     = ACC_W + 1;
    localparam int ROOT_W   = SQ_W / 2;
    localparam int REM_W    = ROOT_W + 3;
    localparam int DREM_W   = ROOT_W;
    localparam int NUM_W    = LIM_W + PROD_W;
    localparam int CNT_W    = 6;

    localparam int MUL1_STEPS = LIM_W;
    localparam int MUL2_STEPS = PROD_W;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int MUL3_STEPS = LIM_W;
    localparam int DIV_STEPS  = NUM_W;

    typedef enum logic [IDX_W-1:0] {
        REG_LIMIT_VX       = 3'd0,
        REG_LIMIT_VY       = 3'd1,
        REG_LIMIT_WZ       = 3'd2,
        REG_TIMEOUT_TICKS  = 3'd3,
        REG_ELLIPSE_ENABLE = 3'd4,
        REG_INVERT_MASK    = 3'd5
    } cfg_index_t;

    typedef enum logic [3:0] {
        C_IDLE,
        C_MUL1,
        C_MUL2,
        C_SUM,
        C_CMP,
        C_SQRT,
        C_MUL3,
        C_DIV,
        C_DONE
    } cap_state_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_CAP,
        S_FINISH
    } top_state_t;

    typedef struct packed {
        logic done;
        logic capped;
    } cap_status_t;

endpackage

FILE: hw/rtl/vcl_cap_unit.sv
`timescale 1ns / 1ps
module vcl_cap_unit
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [vcl_pkg::LIM_W-1:0] ax,
    input  logic [vcl_pkg::LIM_W-1:0] ay,
    input  logic [vcl_pkg::LIM_W-1:0] lx,
    input  logic [vcl_pkg::LIM_W-1:0] ly,
    output vcl_pkg::cap_status_t      status,
    output logic [vcl_pkg::LIM_W-1:0] rx,
    output logic [vcl_pkg::LIM_W-1:0] ry
);

    localparam int AW = vcl_pkg::ACC_W;
    localparam int PW = vcl_pkg::PROD_W;
    localparam int LW = vcl_pkg::LIM_W;
    localparam int RW = vcl_pkg::ROOT_W;
    localparam int MW = vcl_pkg::REM_W;
    localparam int DW = vcl_pkg::DREM_W;
    localparam int CW = vcl_pkg::CNT_W;

    vcl_pkg::cap_state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          last;

    logic [AW-1:0] acc_reg  [3];
    logic [AW-1:0] cand_reg [3];
    logic [PW-1:0] mplr_reg [3];
    logic [AW-1:0] prod     [3];
    logic [PW-1:0] pl_reg;
    logic [vcl_pkg::SQ_W-1:0] s_reg;
    logic [MW-1:0] rem_reg;
    logic [MW-1:0] rem_sh;
    logic [MW-1:0] trial;
    logic [RW-1:0] root_reg;
    logic [DW-1:0] drem_reg [2];
    logic [DW:0]   dtrial   [2];
    logic [LW-1:0] quot_reg [2];
    logic          capped_reg;
    logic [LW-1:0] ax_hold;
    logic [LW-1:0] ay_hold;

    always_comb
    begin
        case (state_reg)
            vcl_pkg::C_MUL1: last = (cnt_reg == CW'(vcl_pkg::MUL1_STEPS - 1));
            vcl_pkg::C_MUL2: last = (cnt_reg == CW'(vcl_pkg::MUL2_STEPS - 1));
            vcl_pkg::C_SQRT: last = (cnt_reg == CW'(vcl_pkg::SQRT_STEPS - 1));
            vcl_pkg::C_MUL3: last = (cnt_reg == CW'(vcl_pkg::MUL3_STEPS - 1));
            vcl_pkg::C_DIV:  last = (cnt_reg == CW'(vcl_pkg::DIV_STEPS - 1));
            default:         last = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            vcl_pkg::C_IDLE: if (start) state_next = vcl_pkg::C_MUL1;
            vcl_pkg::C_MUL1: if (last) state_next = vcl_pkg::C_MUL2;
            vcl_pkg::C_MUL2: if (last) state_next = vcl_pkg::C_SUM;
            vcl_pkg::C_SUM:  state_next = vcl_pkg::C_CMP;
            vcl_pkg::C_CMP:
            begin
                if (s_reg > {1'b0, acc_reg[2]})
                    state_next = vcl_pkg::C_SQRT;
                else
                    state_next = vcl_pkg::C_DONE;
            end
            vcl_pkg::C_SQRT: if (last) state_next = vcl_pkg::C_MUL3;
            vcl_pkg::C_MUL3: if (last) state_next = vcl_pkg::C_DIV;
            vcl_pkg::C_DIV:  if (last) state_next = vcl_pkg::C_DONE;
            vcl_pkg::C_DONE: state_next = vcl_pkg::C_IDLE;
            default:         state_next = vcl_pkg::C_IDLE;
        endcase
    end

    always_comb
    begin
        status.done   = (state_reg == vcl_pkg::C_DONE);
        status.capped = capped_reg;
        case (state_reg)
            vcl_pkg::C_MUL1, vcl_pkg::C_MUL2, vcl_pkg::C_SQRT,
            vcl_pkg::C_MUL3, vcl_pkg::C_DIV:
                cnt_next = last ? '0 : cnt_reg + CW'(1);
            default:
                cnt_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= vcl_pkg::C_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
            prod[k] = acc_reg[k] + (mplr_reg[k][0] ? cand_reg[k] : '0);
        rem_sh = {rem_reg[MW-3:0], s_reg[vcl_pkg::SQ_W-1 -: 2]};
        trial  = MW'({root_reg, 2'b01});
        for (int k = 0; k < 2; k++)
            dtrial[k] = {drem_reg[k], acc_reg[k][AW-1]};
    end

    // shift-add multiply, two-bit restoring root, one-bit restoring divide
    always_ff @(posedge clk)
    begin
        case (state_reg)
            vcl_pkg::C_IDLE:
            begin
                if (start)
                begin
                    cand_reg[0] <= AW'(ly);
                    cand_reg[1] <= AW'(lx);
                    cand_reg[2] <= AW'(ly);
                    mplr_reg[0] <= PW'(ax);
                    mplr_reg[1] <= PW'(ay);
                    mplr_reg[2] <= PW'(lx);
                    for (int k = 0; k < 3; k++)
                        acc_reg[k] <= '0;
                end
            end
            vcl_pkg::C_MUL1:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    if (last)
                    begin
                        cand_reg[k] <= prod[k];
                        mplr_reg[k] <= prod[k][PW-1:0];
                        acc_reg[k]  <= '0;
                    end
                    else
                    begin
                        acc_reg[k]  <= prod[k];
                        cand_reg[k] <= cand_reg[k] << 1;
                        mplr_reg[k] <= mplr_reg[k] >> 1;
                    end
                end
                if (last)
                    pl_reg <= prod[2][PW-1:0];
            end
            vcl_pkg::C_MUL2:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    acc_reg[k]  <= prod[k];
                    cand_reg[k] <= cand_reg[k] << 1;
                    mplr_reg[k] <= mplr_reg[k] >> 1;
                end
            end
            vcl_pkg::C_SUM:
            begin
                s_reg <= {1'b0, acc_reg[0] + acc_reg[1]};
            end
            vcl_pkg::C_CMP:
            begin
                capped_reg  <= (s_reg > {1'b0, acc_reg[2]});
                rem_reg     <= '0;
                root_reg    <= '0;
                acc_reg[0]  <= '0;
                acc_reg[1]  <= '0;
                cand_reg[0] <= AW'(pl_reg);
                cand_reg[1] <= AW'(pl_reg);
                mplr_reg[0] <= PW'(ax_hold);
                mplr_reg[1] <= PW'(ay_hold);
                mplr_reg[2] <= '0;
            end
            vcl_pkg::C_SQRT:
            begin
                s_reg <= s_reg << 2;
                if (rem_sh >= trial)
                begin
                    rem_reg  <= rem_sh - trial;
                    root_reg <= {root_reg[RW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= rem_sh;
                    root_reg <= {root_reg[RW-2:0], 1'b0};
                end
            end
            vcl_pkg::C_MUL3:
            begin
                for (int k = 0; k < 2; k++)
                begin
                    if (last)
                    begin
                        acc_reg[k]  <= prod[k] << (AW - vcl_pkg::NUM_W);
                        drem_reg[k] <= '0;
                        quot_reg[k] <= '0;
                    end
                    else
                    begin
                        acc_reg[k]  <= prod[k];
                        cand_reg[k] <= cand_reg[k] << 1;
                        mplr_reg[k] <= mplr_reg[k] >> 1;
                    end
                end
            end
            vcl_pkg::C_DIV:
            begin
                for (int k = 0; k < 2; k++)
                begin
                    acc_reg[k] <= acc_reg[k] << 1;
                    if (dtrial[k] >= {1'b0, root_reg})
                    begin
                        drem_reg[k] <= DW'(dtrial[k] - {1'b0, root_reg});
                        quot_reg[k] <= {quot_reg[k][LW-2:0], 1'b1};
                    end
                    else
                    begin
                        drem_reg[k] <= dtrial[k][DW-1:0];
                        quot_reg[k] <= {quot_reg[k][LW-2:0], 1'b0};
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == vcl_pkg::C_IDLE && start)
        begin
            ax_hold <= ax;
            ay_hold <= ay;
        end
    end

    assign rx = quot_reg[0];
    assign ry = quot_reg[1];

endmodule

FILE: hw/rtl/velocity_command_limiter_top.sv
`timescale 1ns / 1ps
// Velocity command limiter with staleness watchdog and elliptical cap.
// Input stream s_axis: tuser = func (0 command, 1 tick), tdata = vx, vy, wz.
// A command request is stored and produces no output; a tick request
// produces one drive command on m_axis (tdata = vx, vy, wz; tuser = active).
// Config: cfg_we/cfg_index/cfg_data write one register per clock; the user
// must write only while the block is idle, the block does not enforce it.
// A tick goes straight to the output register when the cap is off or
// inactive, through the squares and a compare when the cap is on and
// not exceeded, and on through scaling when the cap scales: bit-serial
// multiplies (15 + 30 + 15), a 31-step square root and a 45-step divide
// in vcl_cap_unit.
// One request is worked on at a time; s_axis_tready is low while busy.
// A finished result waits in the output register while m_axis_tready is
// low; new commands are still taken meanwhile, a following tick waits.
// Reset: registers take their defaults, no command held, age zero, the
// output stream empty.
module velocity_command_limiter_top
#(
    parameter int VEL_WIDTH = 16,
    parameter int AGE_WIDTH = 16
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // in_vx, in_vy, in_wz, zero pad
    input  logic [((3*VEL_WIDTH+7)/8)*8-1:0]  s_axis_tdata,
    // func
    input  logic                              s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // out_vx, out_vy, out_wz, zero pad
    output logic [((3*VEL_WIDTH+7)/8)*8-1:0]  m_axis_tdata,
    // active
    output logic                              m_axis_tuser,
    input  logic                              cfg_we,
    input  logic [vcl_pkg::IDX_W-1:0]         cfg_index,
    input  logic [vcl_pkg::CFG_W-1:0]         cfg_data
);

    localparam int VW   = VEL_WIDTH;
    localparam int TDW  = ((3*VEL_WIDTH+7)/8)*8;
    localparam int LW   = vcl_pkg::LIM_W;
    localparam int CMPW = (VW + 1 > LW) ? VW + 1 : LW;
    localparam int EXTW = (VW > LW + 1) ? VW : LW + 1;
    localparam int AGW  = (AGE_WIDTH > vcl_pkg::TMO_W) ? AGE_WIDTH : vcl_pkg::TMO_W;

    logic [LW-1:0]                 limit_reg [3];
    logic [vcl_pkg::TMO_W-1:0]     timeout_reg;
    logic                          ellipse_reg;
    logic [vcl_pkg::INV_W-1:0]     invert_reg;

    logic [VW-1:0]        held_reg [3];
    logic [AGE_WIDTH-1:0] age_reg;
    logic                 has_cmd_reg;

    vcl_pkg::top_state_t state_reg, state_next;
    logic                act_reg;
    logic [LW-1:0]       mag_reg [3];
    logic                sgn_reg [3];
    logic                out_valid_reg;
    logic [TDW-1:0]      out_data_reg;
    logic                out_active_reg;

    logic          s_acc;
    logic          m_acc;
    logic          load_out;
    logic          cap_start;
    logic [LW-1:0] mag_c [3];
    logic          sgn_c [3];
    logic [CMPW-1:0] ext_c [3];
    logic [CMPW-1:0] abs_c [3];
    logic [EXTW-1:0] val_c [3];
    logic [LW-1:0] lx_floor;
    logic [LW-1:0] ly_floor;
    logic          act_c;

    vcl_pkg::cap_status_t cap_status;
    logic [LW-1:0]        cap_rx;
    logic [LW-1:0]        cap_ry;

    assign s_acc = s_axis_tvalid && s_axis_tready;
    assign m_acc = m_axis_tvalid && m_axis_tready;
    assign act_c = has_cmd_reg && (AGW'(age_reg) <= AGW'(timeout_reg));
    assign lx_floor = (limit_reg[0] == '0) ? LW'(1) : limit_reg[0];
    assign ly_floor = (limit_reg[1] == '0) ? LW'(1) : limit_reg[1];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ext_c[i] = {{(CMPW-VW){held_reg[i][VW-1]}}, held_reg[i]};
            abs_c[i] = held_reg[i][VW-1] ? (~ext_c[i] + CMPW'(1)) : ext_c[i];
            mag_c[i] = (abs_c[i] > CMPW'(limit_reg[i])) ? limit_reg[i] : abs_c[i][LW-1:0];
            sgn_c[i] = held_reg[i][VW-1] ^ invert_reg[i];
            val_c[i] = sgn_reg[i] ? (~EXTW'(mag_reg[i]) + EXTW'(1)) : EXTW'(mag_reg[i]);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            vcl_pkg::S_IDLE:
                if (s_acc && s_axis_tuser) state_next = vcl_pkg::S_EVAL;
            vcl_pkg::S_EVAL:
                state_next = (act_reg && ellipse_reg) ? vcl_pkg::S_CAP : vcl_pkg::S_FINISH;
            vcl_pkg::S_CAP:
                if (cap_status.done) state_next = vcl_pkg::S_FINISH;
            vcl_pkg::S_FINISH:
                if (!out_valid_reg || m_axis_tready) state_next = vcl_pkg::S_IDLE;
            default:
                state_next = vcl_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        s_axis_tready = (state_reg == vcl_pkg::S_IDLE);
        cap_start     = (state_reg == vcl_pkg::S_EVAL) && act_reg && ellipse_reg;
        load_out      = (state_reg == vcl_pkg::S_FINISH) && (!out_valid_reg || m_axis_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= vcl_pkg::S_IDLE;
            limit_reg[0]  <= LW'(3277);
            limit_reg[1]  <= LW'(2048);
            limit_reg[2]  <= LW'(6144);
            timeout_reg   <= vcl_pkg::TMO_W'(15);
            ellipse_reg   <= 1'b1;
            invert_reg    <= '0;
            age_reg       <= '0;
            has_cmd_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
                held_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (vcl_pkg::cfg_index_t'(cfg_index))
                    vcl_pkg::REG_LIMIT_VX:       limit_reg[0] <= cfg_data[LW-1:0];
                    vcl_pkg::REG_LIMIT_VY:       limit_reg[1] <= cfg_data[LW-1:0];
                    vcl_pkg::REG_LIMIT_WZ:       limit_reg[2] <= cfg_data[LW-1:0];
                    vcl_pkg::REG_TIMEOUT_TICKS:  timeout_reg  <= cfg_data[vcl_pkg::TMO_W-1:0];
                    vcl_pkg::REG_ELLIPSE_ENABLE: ellipse_reg  <= cfg_data[0];
                    vcl_pkg::REG_INVERT_MASK:    invert_reg   <= cfg_data[vcl_pkg::INV_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (s_acc)
            begin
                if (!s_axis_tuser)
                begin
                    held_reg[0] <= s_axis_tdata[VW-1:0];
                    held_reg[1] <= s_axis_tdata[2*VW-1:VW];
                    held_reg[2] <= s_axis_tdata[3*VW-1:2*VW];
                    age_reg     <= '0;
                    has_cmd_reg <= 1'b1;
                end
                else if (age_reg != '1)
                begin
                    age_reg <= age_reg + AGE_WIDTH'(1);
                end
            end
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (m_acc)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_acc && s_axis_tuser)
            act_reg <= act_c;
        if (state_reg == vcl_pkg::S_EVAL)
        begin
            for (int i = 0; i < 3; i++)
            begin
                mag_reg[i] <= act_reg ? mag_c[i] : '0;
                sgn_reg[i] <= sgn_c[i];
            end
        end
        if (state_reg == vcl_pkg::S_CAP && cap_status.done && cap_status.capped)
        begin
            mag_reg[0] <= cap_rx;
            mag_reg[1] <= cap_ry;
        end
        if (load_out)
        begin
            out_data_reg   <= TDW'({val_c[2][VW-1:0], val_c[1][VW-1:0], val_c[0][VW-1:0]});
            out_active_reg <= act_reg;
        end
    end

    vcl_cap_unit u_cap
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cap_start),
        .ax     (mag_c[0]),
        .ay     (mag_c[1]),
        .lx     (lx_floor),
        .ly     (ly_floor),
        .status (cap_status),
        .rx     (cap_rx),
        .ry     (cap_ry)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_active_reg;

`ifndef SYNTHESIS
    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("inactive drive command is not zero");
    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_acc && s_axis_tuser) |=> !s_axis_tready)
        else $error("tick accepted while previous tick in work");
    a_cap_done: assert property (@(posedge clk) disable iff (!rst_n)
        cap_status.done |-> (state_reg == vcl_pkg::S_CAP))
        else $error("cap unit finished outside of cap wait");
`endif

endmodule
